>>> rtl/core/frustum_box_cull_unit_macros.svh
// ----------------------------------------------------------------------------
// Frustum box cull unit assertion macros
// Shared concurrent assertion shorthands for the culling block.
// ----------------------------------------------------------------------------
`ifndef FRUSTUM_BOX_CULL_UNIT_MACROS_SVH
`define FRUSTUM_BOX_CULL_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define FBC_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset
`define FBC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> rtl/core/fbc_pkg.sv
// ----------------------------------------------------------------------------
// Frustum box cull package
// Widths, codes and shared types of the frustum culling block.
// ----------------------------------------------------------------------------
`default_nettype none

package fbc_pkg;

  // Q16.16 coordinates
  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 16;

  // Plane coefficient is a sum or difference of two coordinates
  localparam int COEF_BITS = COORD_BITS + 1;
  // Exact coefficient times coordinate
  localparam int PROD_BITS = COEF_BITS + COORD_BITS;
  // Sum of three products and the scaled offset
  localparam int SUM_BITS  = PROD_BITS + 2;

  localparam int NUM_PLANES = 6;
  localparam int NUM_COEF   = 4;
  localparam int PLANE_BITS = $clog2(NUM_PLANES);
  localparam int COL_BITS   = $clog2(NUM_COEF);

  localparam logic [PLANE_BITS-1:0] LAST_PLANE = PLANE_BITS'(NUM_PLANES - 1);

  // Coefficient slots within one plane row
  localparam logic [COL_BITS-1:0] COL_X   = COL_BITS'(0);
  localparam logic [COL_BITS-1:0] COL_Y   = COL_BITS'(1);
  localparam logic [COL_BITS-1:0] COL_Z   = COL_BITS'(2);
  localparam logic [COL_BITS-1:0] COL_OFF = COL_BITS'(3);

  // Input word opcodes
  localparam logic OP_TEST = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [COEF_BITS-1:0]  coef_t;
  typedef coef_t [NUM_COEF-1:0]         plane_row_t;

  typedef struct packed {
    coord_t min_x;
    coord_t min_y;
    coord_t min_z;
    coord_t max_x;
    coord_t max_y;
    coord_t max_z;
  } box_t;

  // One plane row headed into the evaluator
  typedef struct packed {
    logic       valid;
    logic       last;
    plane_row_t row;
  } plane_req_t;

  // Per-plane outcome from the evaluator
  typedef struct packed {
    logic valid;
    logic last;
    logic reject;
  } plane_verdict_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_TEST,
    ST_DRAIN,
    ST_DELIVER
  } state_t;

endpackage

`default_nettype wire

>>> rtl/core/fbc_ram.sv
// ----------------------------------------------------------------------------
// Frustum box cull RAM
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module fbc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/fbc_plane_eval.sv
// ----------------------------------------------------------------------------
// Frustum box cull plane evaluator
// Three-stage pipeline: positive vertex and products, partial sums, sign.
// ----------------------------------------------------------------------------
`default_nettype none

module fbc_plane_eval (
  input  logic                   clk,
  input  logic                   rst,
  input  fbc_pkg::plane_req_t    req,
  input  fbc_pkg::box_t          box,
  output fbc_pkg::plane_verdict_t verdict
);

  typedef logic signed [fbc_pkg::PROD_BITS-1:0] prod_t;
  typedef logic signed [fbc_pkg::SUM_BITS-1:0]  sum_t;

  fbc_pkg::coef_t  nx, ny, nz, off;
  fbc_pkg::coord_t vx, vy, vz;
  logic            zero_normal;

  // Stage A: products of normal and positive vertex
  logic  a_valid, a_last, a_zero;
  prod_t a_px, a_py, a_pz, a_off;

  // Stage B: pairwise sums
  logic  b_valid, b_last, b_zero;
  sum_t  b_s0, b_s1;
  sum_t  total;

  // Stage C: verdict
  logic  c_valid, c_last, c_reject;

  // Positive vertex: max corner where the normal component is non-negative
  always_comb begin
    nx  = req.row[fbc_pkg::COL_X];
    ny  = req.row[fbc_pkg::COL_Y];
    nz  = req.row[fbc_pkg::COL_Z];
    off = req.row[fbc_pkg::COL_OFF];
    vx  = nx[fbc_pkg::COEF_BITS-1] ? box.min_x : box.max_x;
    vy  = ny[fbc_pkg::COEF_BITS-1] ? box.min_y : box.max_y;
    vz  = nz[fbc_pkg::COEF_BITS-1] ? box.min_z : box.max_z;
    zero_normal = (nx == '0) && (ny == '0) && (nz == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= req.valid;
    end
  end

  // Offset moves to Q33.32 to line up with the products
  always_ff @(posedge clk) begin
    a_last <= req.last;
    a_zero <= zero_normal;
    a_px   <= prod_t'(nx) * prod_t'(vx);
    a_py   <= prod_t'(ny) * prod_t'(vy);
    a_pz   <= prod_t'(nz) * prod_t'(vz);
    a_off  <= prod_t'(off) <<< fbc_pkg::FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    b_last <= a_last;
    b_zero <= a_zero;
    b_s0   <= sum_t'(a_px) + sum_t'(a_py);
    b_s1   <= sum_t'(a_pz) + sum_t'(a_off);
  end

  // Negative distance rejects, unless the normal is all zero
  assign total = b_s0 + b_s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    c_last   <= b_last;
    c_reject <= !b_zero && total[fbc_pkg::SUM_BITS-1];
  end

  assign verdict = '{valid: c_valid, last: c_last, reject: c_reject};

endmodule

`default_nettype wire

>>> rtl/core/frustum_box_cull_unit.sv
// A load word (op = 1) takes one view-projection matrix column and updates
// that column's coefficient in all six frustum planes; it gives no result
// and holds the block until a read-modify-write of each of the six plane
// rows in the coefficient RAM is done. A test word (op = 0) takes a box
// and returns one word, visible = 0 if some plane puts the box fully
// outside. It holds the block while one plane row is read from the RAM
// per cycle and each row passes a read, multiply, add and sign pipeline
// before the verdict is posted. The result sits in an output register, so
// the next word is accepted while the last verdict waits to be taken. After
// reset every plane has a zero normal and every box is visible.
// ----------------------------------------------------------------------------
// Frustum box cull unit
// Positive-vertex culling of axis-aligned boxes against six frustum planes.
// ----------------------------------------------------------------------------
`default_nettype none
`include "frustum_box_cull_unit_macros.svh"

module frustum_box_cull_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                op,
  input  logic [fbc_pkg::COL_BITS-1:0]        column,
  input  logic signed [fbc_pkg::COORD_BITS-1:0] row0_entry,
  input  logic signed [fbc_pkg::COORD_BITS-1:0] row1_entry,
  input  logic signed [fbc_pkg::COORD_BITS-1:0] row2_entry,
  input  logic signed [fbc_pkg::COORD_BITS-1:0] row3_entry,
  input  logic signed [fbc_pkg::COORD_BITS-1:0] box_min_x,
  input  logic signed [fbc_pkg::COORD_BITS-1:0] box_min_y,
  input  logic signed [fbc_pkg::COORD_BITS-1:0] box_min_z,
  input  logic signed [fbc_pkg::COORD_BITS-1:0] box_max_x,
  input  logic signed [fbc_pkg::COORD_BITS-1:0] box_max_y,
  input  logic signed [fbc_pkg::COORD_BITS-1:0] box_max_z,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                visible
);

  fbc_pkg::state_t state, state_next;
  logic [fbc_pkg::PLANE_BITS-1:0] cnt, cnt_next;

  // Captured word
  logic [fbc_pkg::COL_BITS-1:0] ld_col;
  fbc_pkg::coord_t              ld_r0, ld_r1, ld_r2, ld_r3;
  fbc_pkg::box_t                box;

  // Coefficient RAM, one row per plane
  logic                           ram_re, ram_we;
  logic [fbc_pkg::PLANE_BITS-1:0] ram_raddr, ram_waddr;
  fbc_pkg::plane_row_t            ram_rdata, ram_wdata;
  logic [fbc_pkg::NUM_PLANES-1:0] row_ok;
  logic                           rd_ok;
  fbc_pkg::plane_row_t            cur_row;

  // Read-to-write stage of a load
  logic                           wr_pend;
  logic [fbc_pkg::PLANE_BITS-1:0] wr_plane;
  logic [1:0]                     wr_axis;
  fbc_pkg::coord_t                wr_entry;
  fbc_pkg::coef_t                 wr_coef;

  // Test path
  logic                    issue_load, issue_test, out_load;
  logic                    ts_pend, ts_last;
  logic                    cull_acc;
  fbc_pkg::plane_req_t     req;
  fbc_pkg::plane_verdict_t vd;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fbc_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    in_ready   = 1'b0;
    ram_re     = 1'b0;
    issue_load = 1'b0;
    issue_test = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      fbc_pkg::ST_IDLE: begin
        // hold off while the last load row is still being written
        in_ready = !wr_pend;
        if (in_valid && !wr_pend) begin
          cnt_next   = '0;
          state_next = (op == fbc_pkg::OP_LOAD) ? fbc_pkg::ST_LOAD : fbc_pkg::ST_TEST;
        end
      end
      fbc_pkg::ST_LOAD: begin
        ram_re     = 1'b1;
        issue_load = 1'b1;
        if (cnt == fbc_pkg::LAST_PLANE) begin
          state_next = fbc_pkg::ST_IDLE;
        end else begin
          cnt_next = cnt + fbc_pkg::PLANE_BITS'(1);
        end
      end
      fbc_pkg::ST_TEST: begin
        ram_re     = 1'b1;
        issue_test = 1'b1;
        if (cnt == fbc_pkg::LAST_PLANE) begin
          state_next = fbc_pkg::ST_DRAIN;
        end else begin
          cnt_next = cnt + fbc_pkg::PLANE_BITS'(1);
        end
      end
      fbc_pkg::ST_DRAIN: begin
        if (vd.valid && vd.last) begin
          state_next = fbc_pkg::ST_DELIVER;
        end
      end
      fbc_pkg::ST_DELIVER: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = fbc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = fbc_pkg::ST_IDLE;
      end
    endcase
  end

  // Capture the accepted word
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ld_col <= column;
      ld_r0  <= row0_entry;
      ld_r1  <= row1_entry;
      ld_r2  <= row2_entry;
      ld_r3  <= row3_entry;
      box    <= '{min_x: box_min_x, min_y: box_min_y, min_z: box_min_z,
                  max_x: box_max_x, max_y: box_max_y, max_z: box_max_z};
    end
  end

  assign ram_raddr = cnt;

  fbc_ram #(
    .WIDTH($bits(fbc_pkg::plane_row_t)),
    .DEPTH(fbc_pkg::NUM_PLANES)
  ) u_coef_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Row valid bits: a never-written row reads as all zero
  always_ff @(posedge clk) begin
    if (rst) begin
      row_ok  <= '0;
      wr_pend <= 1'b0;
      ts_pend <= 1'b0;
    end else begin
      wr_pend <= issue_load;
      ts_pend <= issue_test;
      if (wr_pend) begin
        row_ok[wr_plane] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      rd_ok <= row_ok[cnt];
    end
    wr_plane <= cnt;
    ts_last  <= (cnt == fbc_pkg::LAST_PLANE);
  end

  assign cur_row = rd_ok ? ram_rdata : '0;

  // Load write-back: plane pairs are row3 plus and minus rows 0, 1, 2
  assign wr_axis = wr_plane[fbc_pkg::PLANE_BITS-1:1];

  always_comb begin
    case (wr_axis)
      2'd0:    wr_entry = ld_r0;
      2'd1:    wr_entry = ld_r1;
      default: wr_entry = ld_r2;
    endcase
    if (wr_plane[0]) begin
      wr_coef = fbc_pkg::coef_t'(ld_r3) - fbc_pkg::coef_t'(wr_entry);
    end else begin
      wr_coef = fbc_pkg::coef_t'(ld_r3) + fbc_pkg::coef_t'(wr_entry);
    end
    ram_wdata         = cur_row;
    ram_wdata[ld_col] = wr_coef;
  end

  assign ram_we    = wr_pend;
  assign ram_waddr = wr_plane;

  // Plane evaluation pipeline
  assign req = '{valid: ts_pend, last: ts_last, row: cur_row};

  fbc_plane_eval u_eval (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .box    (box),
    .verdict(vd)
  );

  // Reject accumulation across the six planes
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cull_acc <= 1'b0;
    end else if (vd.valid) begin
      cull_acc <= cull_acc | vd.reject;
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      visible <= !cull_acc;
    end
  end

  // Load write-back never collides with the row being read
  `FBC_ASSERT_IMPL(a_ram_no_collide, clk, rst, ram_we && ram_re, ram_waddr != ram_raddr)
  // Plane verdicts only arrive during a box test
  `FBC_ASSERT_IMPL(a_verdict_in_test, clk, rst, vd.valid, state == fbc_pkg::ST_TEST || state == fbc_pkg::ST_DRAIN)
  // The last plane's verdict arrives after all reads are issued
  `FBC_ASSERT_IMPL(a_last_in_drain, clk, rst, vd.valid && vd.last, state == fbc_pkg::ST_DRAIN)
  // Posting a verdict leaves a word in the output register
  `FBC_ASSERT_NEXT(a_post_fills_out, clk, rst, out_load, out_valid && state == fbc_pkg::ST_IDLE)

endmodule

`default_nettype wire
